>>> rtl/core/scan_channel_average_accumulator_unit_macros.svh
// Assertion macros shared by the checkers of the scan channel averager.
// Depends on nothing; each macro expects clk and rst in scope.
`ifndef SCAN_CHANNEL_AVERAGE_ACCUMULATOR_UNIT_MACROS_SVH
`define SCAN_CHANNEL_AVERAGE_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SCAA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SCAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Signal unchanged in the cycle after the antecedent, disabled in reset.
`define SCAA_ASSERT_STABLE(label, ante, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> $stable(sig)) \
    else $error(msg);

`endif

>>> rtl/core/scaa_pkg.sv
// Shared constants, codes and types of the scan channel averager.
// No dependencies.
`default_nettype none

package scaa_pkg;

  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_COUNT_BITS   = 32;

  localparam int SAMPLE_BITS = 16;
  localparam int AVG_BITS    = 16;
  localparam int SUM_BITS    = 48;
  localparam int SEL_BITS    = 4;
  localparam int RANK_BITS   = 3;
  localparam int MAX_RANKS   = 8;
  localparam int CCOUNT_BITS = 4;
  localparam int MAP_BITS    = RANK_BITS * MAX_RANKS;
  localparam int STATUS_BITS = 2;
  localparam int STEP_BITS   = $clog2(SUM_BITS);
  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Read status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_SCAN_LEN = 1'b0;
  localparam logic REG_RANK_MAP = 1'b1;

  localparam logic [CCOUNT_BITS-1:0] SCAN_LEN_RST = 4'd1;
  localparam logic [MAP_BITS-1:0]    RANK_MAP_RST = 24'hFAC688;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/scaa_div.sv
// Bit-serial restoring divider: 48-bit dividend by COUNT_BITS divisor.
// Depends on scaa_pkg.
`default_nettype none

module scaa_div #(
  parameter int COUNT_BITS = scaa_pkg::DEF_COUNT_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire  [scaa_pkg::SUM_BITS-1:0]       dividend,
  input  wire  [COUNT_BITS-1:0]               divisor,
  output scaa_pkg::div_stat_t                 stat,
  output logic [scaa_pkg::AVG_BITS-1:0]       quotient
);

  logic                              busy;
  logic                              done;
  logic [scaa_pkg::STEP_BITS-1:0]    step;
  logic [COUNT_BITS-1:0]             rem;
  logic [COUNT_BITS-1:0]             dvs;
  logic [scaa_pkg::SUM_BITS-1:0]     quo;
  logic [COUNT_BITS:0]               trial;
  logic [COUNT_BITS:0]               diff;
  logic                              fits;

  // One quotient bit per cycle: shift in the next dividend bit, try a subtract
  always_comb begin
    trial = {rem, quo[scaa_pkg::SUM_BITS-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == scaa_pkg::STEP_BITS'(scaa_pkg::SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[scaa_pkg::SUM_BITS-2:0], fits};
      rem <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo[scaa_pkg::AVG_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/core/scan_channel_average_accumulator_unit.sv
// Scan channel averager, top level. Depends on scaa_pkg and scaa_div.
// Holds the per-channel sums and counts, the rank counter and the APB registers.
//
// Converted samples arrive as beats in scan order (operation 0). A rank
// counter picks a 3-bit channel from rank_map for each beat and wraps at
// the scan length register (values above eight act as eight, zero drops
// samples); the sample joins that channel's 48-bit sum and its count goes
// up, unless the count is already all ones, in which case the channel holds
// until read. A read beat (operation 1) names a channel and produces one
// result beat with floor(sum / count) and status ok, or status empty when no
// samples arrived since the last read, or status range when the channel does
// not exist; a read of an existing channel clears its sum and count. Samples
// produce no result beat. Steps: a sample is accepted, then the channel entry
// is updated. An empty read is accepted, decoded and cleared, an out-of-range
// read only decoded; both load the output register; else the bit-serial divider
// runs between decode and load, retires one of the 48 quotient bits per
// cycle and then flags done. item_stall stays high from the cycle
// after the accept until the block is idle again. A finished result waits in
// the output register while the next beat is taken; a read that finishes
// while the previous result is still stalled holds in its last cycle.
// Registers: scan length at byte address 0, rank_map at byte address 4;
// only paddr[2] is decoded, write them only while the block is idle.
`default_nettype none

module scan_channel_average_accumulator_unit #(
  parameter int NUM_CHANNELS = scaa_pkg::DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = scaa_pkg::DEF_COUNT_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // APB configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [scaa_pkg::PADDR_BITS-1:0]       paddr,
  input  wire  [scaa_pkg::PDATA_BITS-1:0]       pwdata,
  output logic [scaa_pkg::PDATA_BITS-1:0]       prdata,
  output logic                                  pready,
  // item channel
  input  wire                                   item_valid,
  output logic                                  item_stall,
  input  wire                                   operation,
  input  wire  [scaa_pkg::SAMPLE_BITS-1:0]      sample_value,
  input  wire  [scaa_pkg::SEL_BITS-1:0]         channel_select,
  // result channel
  output logic                                  result_valid,
  input  wire                                   result_stall,
  output logic [scaa_pkg::AVG_BITS-1:0]         average_value,
  output logic [scaa_pkg::STATUS_BITS-1:0]      read_status
);

  localparam int CH_IDX_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_BITS    = scaa_pkg::SEL_BITS + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                                state;
  logic [1:0]                                state_next;

  logic [scaa_pkg::CCOUNT_BITS-1:0]          scan_len;
  logic [scaa_pkg::MAP_BITS-1:0]             rank_map;
  logic [scaa_pkg::RANK_BITS-1:0]            current_rank;

  logic [scaa_pkg::SUM_BITS-1:0]             channel_sum [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]                     channel_sample_count [NUM_CHANNELS];

  // latched item
  logic                                      op_q;
  logic [scaa_pkg::SAMPLE_BITS-1:0]          sample_q;
  logic [scaa_pkg::SEL_BITS-1:0]             sel_q;

  // pending result
  logic [scaa_pkg::AVG_BITS-1:0]             res_avg;
  logic [scaa_pkg::STATUS_BITS-1:0]          res_status;

  logic                                      item_take;
  logic                                      cfg_wr;

  // execute-cycle decode
  logic [scaa_pkg::CCOUNT_BITS-1:0]          n_eff;
  logic [scaa_pkg::RANK_BITS-1:0]            rank_use;
  logic [scaa_pkg::RANK_BITS:0]              rank_inc;
  logic [scaa_pkg::RANK_BITS-1:0]            rank_wrap;
  logic [scaa_pkg::RANK_BITS-1:0]            map_ch;
  logic                                      map_ok;
  logic                                      sel_ok;
  logic [scaa_pkg::SEL_BITS-1:0]             addr;
  logic [CH_IDX_BITS-1:0]                    acc_idx;
  logic [scaa_pkg::SUM_BITS-1:0]             sum_rd;
  logic [COUNT_BITS-1:0]                     cnt_rd;
  logic                                      cnt_full;
  logic                                      wr_en;
  logic [scaa_pkg::SUM_BITS-1:0]             wr_sum;
  logic [COUNT_BITS-1:0]                     wr_cnt;

  logic                                      div_start;
  scaa_pkg::div_stat_t                       div_stat;
  logic [scaa_pkg::AVG_BITS-1:0]             div_quo;

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_len <= scaa_pkg::SCAN_LEN_RST;
      rank_map <= scaa_pkg::RANK_MAP_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        scaa_pkg::REG_SCAN_LEN: scan_len <= pwdata[scaa_pkg::CCOUNT_BITS-1:0];
        scaa_pkg::REG_RANK_MAP: rank_map <= pwdata[scaa_pkg::MAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      scaa_pkg::REG_SCAN_LEN:
        prdata = {{(scaa_pkg::PDATA_BITS - scaa_pkg::CCOUNT_BITS){1'b0}}, scan_len};
      scaa_pkg::REG_RANK_MAP:
        prdata = {{(scaa_pkg::PDATA_BITS - scaa_pkg::MAP_BITS){1'b0}}, rank_map};
      default:
        prdata = '0;
    endcase
  end

  // ---------------- rank and channel decode ----------------
  always_comb begin
    // clamp the scan length to the ranks that rank_map can hold
    n_eff = (scan_len > scaa_pkg::CCOUNT_BITS'(scaa_pkg::MAX_RANKS))
          ? scaa_pkg::CCOUNT_BITS'(scaa_pkg::MAX_RANKS) : scan_len;
    // a rank left beyond a lowered count restarts at rank zero
    rank_use  = ({1'b0, current_rank} < n_eff) ? current_rank : '0;
    rank_inc  = {1'b0, rank_use} + 1'b1;
    rank_wrap = (rank_inc >= n_eff) ? '0 : rank_inc[scaa_pkg::RANK_BITS-1:0];
    map_ch    = rank_map[scaa_pkg::RANK_BITS * rank_use +: scaa_pkg::RANK_BITS];
    map_ok    = {{(CMP_BITS - scaa_pkg::RANK_BITS){1'b0}}, map_ch} < CMP_BITS'(NUM_CHANNELS);
    sel_ok    = {1'b0, sel_q} < CMP_BITS'(NUM_CHANNELS);
    addr      = (op_q == scaa_pkg::OP_READ) ? sel_q
              : {{(scaa_pkg::SEL_BITS - scaa_pkg::RANK_BITS){1'b0}}, map_ch};
    acc_idx   = addr[CH_IDX_BITS-1:0];
    sum_rd    = channel_sum[acc_idx];
    cnt_rd    = channel_sample_count[acc_idx];
    cnt_full  = &cnt_rd;
  end

  // one write port on the channel table
  always_comb begin
    wr_en  = 1'b0;
    wr_sum = sum_rd + scaa_pkg::SUM_BITS'(sample_q);
    wr_cnt = cnt_rd + 1'b1;
    if (state == S_EXEC) begin
      if (op_q == scaa_pkg::OP_READ) begin
        // read and clear
        wr_en  = sel_ok;
        wr_sum = '0;
        wr_cnt = '0;
      end else begin
        wr_en = (n_eff != '0) && map_ok && !cnt_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_sum[i]          <= '0;
        channel_sample_count[i] <= '0;
      end
    end else if (wr_en) begin
      channel_sum[acc_idx]          <= wr_sum;
      channel_sample_count[acc_idx] <= wr_cnt;
    end
  end

  // ---------------- sequencer ----------------
  assign div_start = (state == S_EXEC) && (op_q == scaa_pkg::OP_READ) && sel_ok
                   && (cnt_rd != '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (item_take) state_next = S_EXEC;
      S_EXEC: begin
        if (op_q == scaa_pkg::OP_SAMPLE) state_next = S_IDLE;
        else if (div_start)              state_next = S_DIV;
        else                             state_next = S_DONE;
      end
      S_DIV:  if (div_stat.done) state_next = S_DONE;
      S_DONE: if (!result_valid || !result_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      current_rank <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && op_q == scaa_pkg::OP_SAMPLE) begin
        // advance the rank even when the mapped channel drops the sample
        current_rank <= (n_eff == '0) ? '0 : rank_wrap;
      end
    end
  end

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (item_take) begin
      op_q     <= operation;
      sample_q <= sample_value;
      sel_q    <= channel_select;
    end
  end

  // build the pending result
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_avg    <= '0;
      res_status <= sel_ok ? scaa_pkg::ST_EMPTY : scaa_pkg::ST_RANGE;
    end else if (state == S_DIV && div_stat.done) begin
      res_avg    <= div_quo;
      res_status <= scaa_pkg::ST_OK;
    end
  end

  // output register: load when free or draining, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      average_value <= res_avg;
      read_status   <= res_status;
    end
  end

  scaa_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_rd),
    .divisor  (cnt_rd),
    .stat     (div_stat),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

>>> rtl/core/scaa_checker.sv
// Port-level checker for the scan channel averager, bound to the top level.
// Depends on scaa_pkg and the assertion macro header.
`default_nettype none
`include "scan_channel_average_accumulator_unit_macros.svh"

module scaa_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 item_valid,
  input wire                                 item_stall,
  input wire                                 result_valid,
  input wire                                 result_stall,
  input wire [scaa_pkg::AVG_BITS-1:0]        average_value,
  input wire [scaa_pkg::STATUS_BITS-1:0]     read_status
);

  logic                                            item_take;
  logic                                            res_wait;
  logic                                            res_failed;
  logic                                            status_known;
  logic [scaa_pkg::AVG_BITS+scaa_pkg::STATUS_BITS-1:0] res_word;

  assign item_take    = item_valid && !item_stall;
  assign res_wait     = result_valid && result_stall;
  assign res_failed   = result_valid && (read_status != scaa_pkg::ST_OK);
  assign status_known = read_status inside {scaa_pkg::ST_OK, scaa_pkg::ST_EMPTY,
                                            scaa_pkg::ST_RANGE};
  assign res_word     = {average_value, read_status};

  // a stalled result beat holds
  `SCAA_ASSERT_NEXT(a_result_held, res_wait, result_valid, "stalled result beat dropped")
  `SCAA_ASSERT_STABLE(a_result_stable, res_wait, res_word, "stalled result beat changed")

  // only the three defined status codes leave the block
  `SCAA_ASSERT_NOW(a_status_code, result_valid, status_known, "undefined read status")

  // no average without a successful read
  `SCAA_ASSERT_NOW(a_avg_zero, res_failed, average_value == '0, "average on failed read")

  // every accepted beat occupies the block and raises item_stall
  `SCAA_ASSERT_NEXT(a_busy_after_take, item_take, item_stall, "input open after a beat")

endmodule

bind scan_channel_average_accumulator_unit scaa_checker u_scaa_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_stall    (item_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .average_value (average_value),
  .read_status   (read_status)
);

`default_nettype wire
